>>> design/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, constants and arithmetic helpers for the pressure and
// temperature compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int unsigned DIV_W = 64;

    localparam logic [63:0] OFFSET_FINE = 64'd128000;
    localparam logic [63:0] PRESS_FULL  = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE = 64'd3125;
    localparam logic [63:0] LIN_BIAS    = 64'h0000_8000_0000_0000;

    typedef enum logic [2:0] {
        REG_T1    = 3'd0,
        REG_T2    = 3'd1,
        REG_T3    = 3'd2,
        REG_P1_P4 = 3'd3,
        REG_P5_P8 = 3'd4,
        REG_P9    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [63:0] p1_p4;
        logic [63:0] p5_p8;
        logic [15:0] p9;
    } cal_t;

    typedef struct packed {
        logic [63:0] x;
        logic [31:0] fine;
        logic [31:0] cent;
        logic [19:0] adc_press;
    } temp_res_t;

    typedef struct packed {
        logic [31:0] fine;
        logic [31:0] cent;
        logic        neg;
        logic        invalid;
    } side_t;

    // 64x64 product modulo 2^64 as three 32x32 partial products
    typedef struct packed {
        logic [63:0] ll;
        logic [31:0] lh;
        logic [31:0] hl;
    } mul_pp_t;

    function automatic logic [63:0] sx16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic [63:0] asr(input logic [63:0] v, input int unsigned n);
        return $unsigned($signed(v) >>> n);
    endfunction

    function automatic mul_pp_t mul_parts(input logic [63:0] a, input logic [63:0] b);
        mul_pp_t pp;
        pp.ll = a[31:0] * b[31:0];
        pp.lh = a[31:0] * b[63:32];
        pp.hl = a[63:32] * b[31:0];
        return pp;
    endfunction

    function automatic logic [63:0] mul_sum(input mul_pp_t pp);
        return pp.ll + {pp.lh + pp.hl, 32'h0};
    endfunction

    // (fine * 5 + 128) >>> 8
    function automatic logic [31:0] centi_of(input logic [31:0] f);
        logic signed [35:0] w;
        logic signed [35:0] r;
        w = $signed({{4{f[31]}}, f});
        w = (w <<< 2) + w + 36'sd128;
        r = w >>> 8;
        return r[31:0];
    endfunction

endpackage

>>> design/ptc_temp.sv
// ----------------------------------------------------------------------------
// ptc_temp
// Five-stage temperature section: fine temperature, centidegrees and the
// offset fine value that feeds the pressure polynomial.
// ----------------------------------------------------------------------------
module ptc_temp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [19:0]          adc_temp,
    input  logic [19:0]          adc_press,
    input  ptc_pkg::cal_t        cal,
    output logic                 out_valid,
    output ptc_pkg::temp_res_t   res
);

    logic [4:0]         vld_reg;
    logic [19:0]        press_reg [5];

    logic signed [18:0] a_reg, a_next;
    logic signed [18:0] d_reg, d_next;
    logic signed [34:0] m1_reg, m1_next;
    logic signed [37:0] dd_reg, dd_next;
    logic signed [23:0] v1t_reg, v1t_next;
    logic signed [41:0] m2_reg, m2_next;
    logic [31:0]        fine4_reg, fine_next;
    logic [31:0]        fine5_reg;
    logic [31:0]        cent_reg, cent_next;
    logic [63:0]        x_reg, x_next;

    logic signed [34:0] m1_sh;
    logic signed [37:0] dd_sh;
    logic signed [41:0] sum42;

    always_comb
    begin
        a_next    = $signed({2'b00, adc_temp[19:3]}) - $signed({2'b00, cal.t1, 1'b0});
        d_next    = $signed({3'b000, adc_temp[19:4]}) - $signed({3'b000, cal.t1});
        m1_next   = a_reg * $signed(cal.t2);
        dd_next   = d_reg * d_reg;
        m1_sh     = m1_reg >>> 11;
        v1t_next  = m1_sh[23:0];
        dd_sh     = dd_reg >>> 12;
        m2_next   = $signed(dd_sh[25:0]) * $signed(cal.t3);
        sum42     = (m2_reg >>> 14) + v1t_reg;
        fine_next = sum42[31:0];
        x_next    = {{32{fine4_reg[31]}}, fine4_reg} - ptc_pkg::OFFSET_FINE;
        cent_next = ptc_pkg::centi_of(fine4_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            press_reg[0] <= adc_press;
            for (int k = 1; k < 5; k++)
            begin
                press_reg[k] <= press_reg[k-1];
            end
            a_reg     <= a_next;
            d_reg     <= d_next;
            m1_reg    <= m1_next;
            dd_reg    <= dd_next;
            v1t_reg   <= v1t_next;
            m2_reg    <= m2_next;
            fine4_reg <= fine_next;
            fine5_reg <= fine4_reg;
            cent_reg  <= cent_next;
            x_reg     <= x_next;
        end
    end

    assign out_valid     = vld_reg[4];
    assign res.x         = x_reg;
    assign res.fine      = fine5_reg;
    assign res.cent      = cent_reg;
    assign res.adc_press = press_reg[4];

endmodule

>>> design/ptc_poly.sv
// ----------------------------------------------------------------------------
// ptc_poly
// Eight-stage pressure polynomial: builds the dividend and divisor and
// hands their magnitudes and the quotient sign to the divider.
// ----------------------------------------------------------------------------
module ptc_poly (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  ptc_pkg::temp_res_t   src,
    input  ptc_pkg::cal_t        cal,
    output logic                 out_valid,
    output logic [63:0]          ma,
    output logic [63:0]          mb,
    output ptc_pkg::side_t       side
);

    logic [7:0]          vld_reg;
    ptc_pkg::temp_res_t  carry_reg [8];

    ptc_pkg::mul_pp_t    xx_pp_reg, b_pp_reg, c_pp_reg;
    logic [63:0]         xx_reg, b2_reg, c2_reg;
    ptc_pkg::mul_pp_t    a_pp_reg, d_pp_reg;
    logic [63:0]         b3_reg, c3_reg;
    logic [63:0]         a_reg, d_reg, b4_reg, c4_reg;
    logic [63:0]         v2_reg, g_reg;
    ptc_pkg::mul_pp_t    h_pp_reg, n_pp_reg;
    logic [63:0]         h_reg, num_reg;
    logic [63:0]         ma_reg, mb_reg;
    logic                neg_reg, inv_reg;

    logic [63:0] p1, p2, p3, p4, p5, p6;
    logic [63:0] v2_next, g_next, nb, dvs;

    always_comb
    begin
        p1      = {48'h0, cal.p1_p4[15:0]};
        p2      = ptc_pkg::sx16(cal.p1_p4[31:16]);
        p3      = ptc_pkg::sx16(cal.p1_p4[47:32]);
        p4      = ptc_pkg::sx16(cal.p1_p4[63:48]);
        p5      = ptc_pkg::sx16(cal.p5_p8[15:0]);
        p6      = ptc_pkg::sx16(cal.p5_p8[31:16]);
        v2_next = a_reg + (b4_reg << 17) + (p4 << 35);
        g_next  = ptc_pkg::asr(d_reg, 8) + (c4_reg << 12) + ptc_pkg::LIN_BIAS;
        nb      = ((ptc_pkg::PRESS_FULL - {44'h0, carry_reg[4].adc_press}) << 31) - v2_reg;
        dvs     = ptc_pkg::asr(h_reg, 33);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            carry_reg[0] <= src;
            for (int k = 1; k < 8; k++)
            begin
                carry_reg[k] <= carry_reg[k-1];
            end
            xx_pp_reg <= ptc_pkg::mul_parts(src.x, src.x);
            b_pp_reg  <= ptc_pkg::mul_parts(src.x, p5);
            c_pp_reg  <= ptc_pkg::mul_parts(src.x, p2);
            xx_reg    <= ptc_pkg::mul_sum(xx_pp_reg);
            b2_reg    <= ptc_pkg::mul_sum(b_pp_reg);
            c2_reg    <= ptc_pkg::mul_sum(c_pp_reg);
            a_pp_reg  <= ptc_pkg::mul_parts(xx_reg, p6);
            d_pp_reg  <= ptc_pkg::mul_parts(xx_reg, p3);
            b3_reg    <= b2_reg;
            c3_reg    <= c2_reg;
            a_reg     <= ptc_pkg::mul_sum(a_pp_reg);
            d_reg     <= ptc_pkg::mul_sum(d_pp_reg);
            b4_reg    <= b3_reg;
            c4_reg    <= c3_reg;
            v2_reg    <= v2_next;
            g_reg     <= g_next;
            h_pp_reg  <= ptc_pkg::mul_parts(g_reg, p1);
            n_pp_reg  <= ptc_pkg::mul_parts(nb, ptc_pkg::PRESS_SCALE);
            h_reg     <= ptc_pkg::mul_sum(h_pp_reg);
            num_reg   <= ptc_pkg::mul_sum(n_pp_reg);
            // divide on magnitudes, restore the sign afterwards
            inv_reg   <= (dvs == '0);
            neg_reg   <= num_reg[63] ^ dvs[63];
            ma_reg    <= num_reg[63] ? -num_reg : num_reg;
            mb_reg    <= dvs[63] ? -dvs : dvs;
        end
    end

    assign out_valid    = vld_reg[7];
    assign ma           = ma_reg;
    assign mb           = mb_reg;
    assign side.fine    = carry_reg[7].fine;
    assign side.cent    = carry_reg[7].cent;
    assign side.neg     = neg_reg;
    assign side.invalid = inv_reg;

endmodule

>>> design/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ptc_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [63:0]      ma,
    input  logic [63:0]      mb,
    input  ptc_pkg::side_t   side_in,
    output logic             out_valid,
    output logic [63:0]      quo,
    output ptc_pkg::side_t   side_out
);

    localparam int unsigned N = ptc_pkg::DIV_W;

    logic [N-1:0]   vld_reg;
    logic [63:0]    rem_reg  [N];
    logic [63:0]    dq_reg   [N];
    logic [63:0]    dv_reg   [N];
    ptc_pkg::side_t side_reg [N];

    logic [63:0]    rem_in   [N];
    logic [63:0]    dq_in    [N];
    logic [63:0]    dv_in    [N];
    ptc_pkg::side_t side_src [N];
    logic [63:0]    rem_next [N];
    logic [63:0]    dq_next  [N];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            logic [64:0] trial;
            logic [64:0] diff;

            if (k == 0)
            begin : g_first
                assign rem_in[k]   = '0;
                assign dq_in[k]    = ma;
                assign dv_in[k]    = mb;
                assign side_src[k] = side_in;
            end
            else
            begin : g_next
                assign rem_in[k]   = rem_reg[k-1];
                assign dq_in[k]    = dq_reg[k-1];
                assign dv_in[k]    = dv_reg[k-1];
                assign side_src[k] = side_reg[k-1];
            end

            always_comb
            begin
                trial = {rem_in[k], dq_in[k][63]};
                diff  = trial - {1'b0, dv_in[k]};
                if (trial >= {1'b0, dv_in[k]})
                begin
                    rem_next[k] = diff[63:0];
                    dq_next[k]  = {dq_in[k][62:0], 1'b1};
                end
                else
                begin
                    rem_next[k] = trial[63:0];
                    dq_next[k]  = {dq_in[k][62:0], 1'b0};
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                dq_reg[i]   <= dq_next[i];
                dv_reg[i]   <= dv_in[i];
                side_reg[i] <= side_src[i];
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign quo       = dq_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

>>> design/ptc_post.sv
// ----------------------------------------------------------------------------
// ptc_post
// Six-stage pressure correction after the divide, ending in the output
// register.
// ----------------------------------------------------------------------------
module ptc_post (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [63:0]      quo,
    input  ptc_pkg::side_t   side,
    input  ptc_pkg::cal_t    cal,
    output logic             out_valid,
    output logic [31:0]      temp_centi,
    output logic [31:0]      temp_fine,
    output logic [31:0]      press_q24_8,
    output logic             press_invalid
);

    logic [5:0]       vld_reg;
    ptc_pkg::side_t   side_reg [5];

    logic [63:0]      p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic [63:0]      s2_reg, s3_reg;
    ptc_pkg::mul_pp_t e_pp_reg, g_pp_reg, f_pp_reg;
    logic [63:0]      e_reg, g3_reg, g4_reg, g5_reg, f_reg;
    logic [31:0]      centi_reg, fine_reg, press_reg;
    logic             inv_reg;

    logic [63:0] s_next, p7, p8, p9, r_next;

    always_comb
    begin
        p7     = ptc_pkg::sx16(cal.p5_p8[47:32]);
        p8     = ptc_pkg::sx16(cal.p5_p8[63:48]);
        p9     = ptc_pkg::sx16(cal.p9);
        s_next = ptc_pkg::asr(p1_reg, 13);
        r_next = ptc_pkg::asr(p5_reg + ptc_pkg::asr(f_reg, 25) + ptc_pkg::asr(g5_reg, 19), 8)
                 + (p7 << 4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side;
            for (int k = 1; k < 5; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            p1_reg    <= side.neg ? -quo : quo;
            e_pp_reg  <= ptc_pkg::mul_parts(s_next, p9);
            g_pp_reg  <= ptc_pkg::mul_parts(p1_reg, p8);
            p2_reg    <= p1_reg;
            s2_reg    <= s_next;
            e_reg     <= ptc_pkg::mul_sum(e_pp_reg);
            g3_reg    <= ptc_pkg::mul_sum(g_pp_reg);
            p3_reg    <= p2_reg;
            s3_reg    <= s2_reg;
            f_pp_reg  <= ptc_pkg::mul_parts(e_reg, s3_reg);
            g4_reg    <= g3_reg;
            p4_reg    <= p3_reg;
            f_reg     <= ptc_pkg::mul_sum(f_pp_reg);
            g5_reg    <= g4_reg;
            p5_reg    <= p4_reg;
            // zero divisor: force pressure to zero
            centi_reg <= side_reg[4].cent;
            fine_reg  <= side_reg[4].fine;
            inv_reg   <= side_reg[4].invalid;
            press_reg <= side_reg[4].invalid ? 32'h0 : r_next[31:0];
        end
    end

    assign out_valid     = vld_reg[5];
    assign temp_centi    = centi_reg;
    assign temp_fine     = fine_reg;
    assign press_q24_8   = press_reg;
    assign press_invalid = inv_reg;

endmodule

>>> design/pressure_temp_compensation_top.sv
// ----------------------------------------------------------------------------
// pressure_temp_compensation_top
// Integer compensation of raw temperature and pressure readings.
//
// Input channel (in_valid/in_ready) carries adc_temp and adc_press; each
// transaction gives exactly one output transaction (out_valid/out_ready)
// with temp_centi, temp_fine, press_q24_8 and press_invalid.
// Calibration words are written over cfg_valid/cfg_ready with cfg_index
// and cfg_data; cfg_ready is always high. Write them only while idle.
// The pipeline has 5 temperature stages, 8 polynomial stages, a
// 64-stage divider taking one quotient bit per stage, and 6 correction
// stages. One transaction is accepted per cycle when the output is free.
// When the receiver stalls the whole pipeline holds and in_ready drops;
// nothing is lost or repeated. Reset clears the calibration words to zero
// and empties the pipeline.
// ----------------------------------------------------------------------------
module pressure_temp_compensation_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [19:0] adc_temp,
    input  logic [19:0] adc_press,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] temp_centi,
    output logic [31:0] temp_fine,
    output logic [31:0] press_q24_8,
    output logic        press_invalid,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    ptc_pkg::cal_t      cal_reg;
    logic               en;
    logic               t_valid, p_valid, d_valid;
    ptc_pkg::temp_res_t t_res;
    logic [63:0]        ma, mb, quo;
    ptc_pkg::side_t     p_side, d_side;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid || out_ready;
    assign in_ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (ptc_pkg::cfg_reg_t'(cfg_index))
                ptc_pkg::REG_T1:    cal_reg.t1    <= cfg_data[15:0];
                ptc_pkg::REG_T2:    cal_reg.t2    <= cfg_data[15:0];
                ptc_pkg::REG_T3:    cal_reg.t3    <= cfg_data[15:0];
                ptc_pkg::REG_P1_P4: cal_reg.p1_p4 <= cfg_data;
                ptc_pkg::REG_P5_P8: cal_reg.p5_p8 <= cfg_data;
                ptc_pkg::REG_P9:    cal_reg.p9    <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    ptc_temp u_temp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .adc_temp  (adc_temp),
        .adc_press (adc_press),
        .cal       (cal_reg),
        .out_valid (t_valid),
        .res       (t_res)
    );

    ptc_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t_valid),
        .src       (t_res),
        .cal       (cal_reg),
        .out_valid (p_valid),
        .ma        (ma),
        .mb        (mb),
        .side      (p_side)
    );

    ptc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid),
        .ma        (ma),
        .mb        (mb),
        .side_in   (p_side),
        .out_valid (d_valid),
        .quo       (quo),
        .side_out  (d_side)
    );

    ptc_post u_post (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (d_valid),
        .quo           (quo),
        .side          (d_side),
        .cal           (cal_reg),
        .out_valid     (out_valid),
        .temp_centi    (temp_centi),
        .temp_fine     (temp_fine),
        .press_q24_8   (press_q24_8),
        .press_invalid (press_invalid)
    );

    a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && press_invalid |-> press_q24_8 == 32'h0)
        else $error("invalid pressure not forced to zero");

    a_centi_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> temp_centi == ptc_pkg::centi_of(temp_fine))
        else $error("temperature fields out of step");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with free output");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the temperature and pressure compensation pipeline against its own
// 64-bit integer predictor. Drives measurements in random bursts, stalls the
// output on a separate pattern and walks through several calibration sets,
// zero and extreme words among them.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic [31:0] centi;
        logic [31:0] fine;
        logic [31:0] press;
        logic        invalid;
    } comp_res_t;

    class comp_scoreboard;
        logic [15:0] t1, t2, t3, p9;
        logic [63:0] p1p4, p5p8;
        comp_res_t   pending[$];
        int          errors;
        int          checked;
        int          n_invalid;

        function void set_reg(ptc_pkg::cfg_reg_t idx, logic [63:0] v);
            case (idx)
                ptc_pkg::REG_T1:    t1 = v[15:0];
                ptc_pkg::REG_T2:    t2 = v[15:0];
                ptc_pkg::REG_T3:    t3 = v[15:0];
                ptc_pkg::REG_P1_P4: p1p4 = v;
                ptc_pkg::REG_P5_P8: p5p8 = v;
                ptc_pkg::REG_P9:    p9 = v[15:0];
                default:            ;
            endcase
        endfunction

        function void note_input(logic [19:0] at, logic [19:0] ap);
            longint a1, a2, p1, p2, p3, p4, p5, p6, p7, p8, pp9, tt1, tt2, tt3;
            longint v1, v2, d, fine, p, s;
            longint unsigned ua, ub, uq;
            comp_res_t r;
            tt1 = {48'd0, t1};
            tt2 = {{48{t2[15]}}, t2};
            tt3 = {{48{t3[15]}}, t3};
            p1 = {48'd0, p1p4[15:0]};
            p2 = {{48{p1p4[31]}}, p1p4[31:16]};
            p3 = {{48{p1p4[47]}}, p1p4[47:32]};
            p4 = {{48{p1p4[63]}}, p1p4[63:48]};
            p5 = {{48{p5p8[15]}}, p5p8[15:0]};
            p6 = {{48{p5p8[31]}}, p5p8[31:16]};
            p7 = {{48{p5p8[47]}}, p5p8[47:32]};
            p8 = {{48{p5p8[63]}}, p5p8[63:48]};
            pp9 = {{48{p9[15]}}, p9};
            a1 = {44'd0, at};
            a2 = {44'd0, ap};
            v1 = (((a1 >>> 3) - (tt1 <<< 1)) * tt2) >>> 11;
            d = (a1 >>> 4) - tt1;
            v2 = (((d * d) >>> 12) * tt3) >>> 14;
            fine = v1 + v2;
            r.centi = 32'((fine * 5 + 128) >>> 8);
            r.fine = 32'(fine);
            v1 = fine - 128000;
            v2 = v1 * v1 * p6;
            v2 = v2 + ((v1 * p5) <<< 17);
            v2 = v2 + (p4 <<< 35);
            v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
            v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
            r.press = '0;
            r.invalid = 1'b0;
            if (v1 == 0)
            begin
                r.invalid = 1'b1;
                n_invalid++;
            end
            else
            begin
                p = 1048576 - a2;
                p = ((p <<< 31) - v2) * 3125;
                // truncating divide on magnitudes; most negative over -1 wraps
                ua = p < 0 ? -p : p;
                ub = v1 < 0 ? -v1 : v1;
                uq = ua / ub;
                p = ((p < 0) != (v1 < 0)) ? -longint'(uq) : longint'(uq);
                s = p >>> 13;
                v1 = (pp9 * s * s) >>> 25;
                v2 = (p8 * p) >>> 19;
                p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
                r.press = p[31:0];
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] c, logic [31:0] f, logic [31:0] pr,
                                   logic inv);
            comp_res_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (c !== e.centi)
            begin
                $error("temp_centi expected %h actual %h", e.centi, c);
                errors++;
            end
            if (f !== e.fine)
            begin
                $error("temp_fine expected %h actual %h", e.fine, f);
                errors++;
            end
            if (pr !== e.press)
            begin
                $error("press_q24_8 expected %h actual %h", e.press, pr);
                errors++;
            end
            if (inv !== e.invalid)
            begin
                $error("press_invalid expected %b actual %b", e.invalid, inv);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [19:0] adc_temp = '0;
    logic [19:0] adc_press = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] temp_centi, temp_fine, press_q24_8;
    logic        press_invalid;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    comp_scoreboard sb;
    bit  hold_off = 0;
    int  idle_cycles = 0;
    int  n_items = 0;
    int  n_cfg = 0;

    localparam int LATENCY = 83;
    localparam int IDLE_LIMIT = 20000;

    always #5 clk = ~clk;

    pressure_temp_compensation_top u_top (.*);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (in_valid && in_ready)
                sb.note_input(adc_temp, adc_press);
            if (out_valid && out_ready)
                sb.check_result(temp_centi, temp_fine, press_q24_8, press_invalid);
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // receiver stall pattern, plus a long hold-off on request
    initial
    begin
        int mode;
        mode = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                out_ready <= 1'b0;
            else
            begin
                if ($urandom_range(0, 199) == 0)
                    mode = $urandom_range(0, 2);
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_item(logic [19:0] at, logic [19:0] ap);
        adc_temp <= at;
        adc_press <= ap;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        n_items++;
        @(negedge clk);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
    endtask

    task automatic random_gap();
        int g;
        g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
        if (g > 0)
        begin
            drop_valid();
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic drain();
        drop_valid();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    task automatic write_reg(ptc_pkg::cfg_reg_t idx, logic [63:0] v);
        cfg_index <= idx;
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, v);
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_cal(logic [15:0] t1, logic [15:0] t2, logic [15:0] t3,
                            logic [63:0] p14, logic [63:0] p58, logic [15:0] p9);
        write_reg(ptc_pkg::REG_T1, 64'(t1));
        write_reg(ptc_pkg::REG_T2, 64'(t2));
        write_reg(ptc_pkg::REG_T3, 64'(t3));
        write_reg(ptc_pkg::REG_P1_P4, p14);
        write_reg(ptc_pkg::REG_P5_P8, p58);
        write_reg(ptc_pkg::REG_P9, 64'(p9));
    endtask

    // typical factory words in the packed layout
    task automatic load_typical();
        load_cal(16'd27504, 16'd26435, -16'sd1000,
                 {-16'sd3000, 16'd4000, -16'sd10715, 16'd36477},
                 {16'd15500, -16'sd14600, -16'sd7, 16'd140}, 16'd6000);
    endtask

    task automatic random_phase(int count, bit realistic);
        for (int i = 0; i < count; i++)
        begin
            if (realistic)
                send_item(20'($urandom_range(400000, 600000)),
                          20'($urandom_range(200000, 700000)));
            else
                send_item(20'($urandom), 20'($urandom));
            random_gap();
        end
    endtask

    initial
    begin
        logic [19:0] edge_vals[4];
        sb = new();
        sb.set_reg(ptc_pkg::REG_T1, '0);
        sb.set_reg(ptc_pkg::REG_T2, '0);
        sb.set_reg(ptc_pkg::REG_T3, '0);
        sb.set_reg(ptc_pkg::REG_P1_P4, '0);
        sb.set_reg(ptc_pkg::REG_P5_P8, '0);
        sb.set_reg(ptc_pkg::REG_P9, '0);
        edge_vals = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF};
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset calibration: divisor is zero, pressure flagged invalid
        send_item(20'd519888, 20'd415148);
        send_item(20'hFFFFF, 20'h00000);
        drain();

        load_typical();
        foreach (edge_vals[a])
            foreach (edge_vals[b])
                send_item(edge_vals[a], edge_vals[b]);
        send_item(20'd519888, 20'd415148);
        send_item(20'd440000, 20'd655360);
        drain();

        // extremes of every word: overflow and wrap paths
        load_cal(16'hFFFF, 16'h7FFF, 16'h8000, 64'h8000_7FFF_8000_FFFF,
                 64'h7FFF_8000_7FFF_8000, 16'h7FFF);
        random_phase(60, 0);
        drain();
        load_cal(16'h0000, 16'h8000, 16'h7FFF, 64'h7FFF_8000_7FFF_0001,
                 64'h8000_7FFF_8000_7FFF, 16'h8000);
        random_phase(60, 0);
        drain();

        // long receiver hold-off while the sender keeps offering
        load_typical();
        fork
            begin
                hold_off = 1;
                repeat (300) @(negedge clk);
                hold_off = 0;
            end
            random_phase(200, 1);
        join
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            load_cal(16'($urandom), 16'($urandom), 16'($urandom), {$urandom, $urandom},
                     {$urandom, $urandom}, 16'($urandom));
            // an odd out-of-list index is ignored
            write_reg(ptc_pkg::cfg_reg_t'(3'(6 + ($urandom & 1))), {$urandom, $urandom});
            random_phase(45, 0);
            drain();
        end

        load_typical();
        random_phase(300, 1);
        drain();

        $display("covered %0d measurements, %0d register writes, %0d invalid pressures",
                 n_items, n_cfg, sb.n_invalid);
        $display("results checked: %0d, mismatches: %0d", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

>>> sim.f
design/ptc_pkg.sv
design/ptc_temp.sv
design/ptc_poly.sv
design/ptc_div.sv
design/ptc_post.sv
design/pressure_temp_compensation_top.sv
tb/testbench.sv
